### hw/rtl/mcct_pkg.sv
// Shared types, constants and register indexes for the multi-color chase unit.
// No dependencies; every other file of the block imports this package.
package mcct_pkg;

	localparam int MAX_LEDS = 64;

	localparam int COLOR_W = 24;
	localparam int TRAIL_W = 5;
	localparam int GAP_W   = 6;
	localparam int SPEED_W = 10;
	localparam int LED_W   = 7;
	localparam int CYC_W   = 8;
	localparam int POS_W   = 9;
	localparam int ACC_W   = 11;
	localparam int IDX_W   = 6;
	localparam int CH_W    = 8;
	localparam int SP_W    = 7;
	localparam int DIST_W  = 11;

	localparam int NUM_W   = 13;
	localparam int DEN_W   = 6;
	localparam int QUOT_W  = 8;
	localparam int DCNT_W  = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_GAP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 3'd7;

	localparam logic [COLOR_W-1:0] RST_COLOR_FIRST  = 24'hFF0000;
	localparam logic [COLOR_W-1:0] RST_COLOR_SECOND = 24'h00FF00;
	localparam logic [COLOR_W-1:0] RST_COLOR_THIRD  = 24'h0000FF;
	localparam logic [TRAIL_W-1:0] RST_TRAIL        = 5'd5;
	localparam logic [GAP_W-1:0]   RST_GAP          = 6'd0;
	localparam logic [SPEED_W-1:0] RST_SPEED        = 10'd100;
	localparam logic [LED_W-1:0]   RST_LED_COUNT    = 7'd64;
	localparam logic [CYC_W-1:0]   RST_TARGET       = 8'd1;

	localparam logic [ACC_W-1:0] STEP_UNIT = 11'd100;
	localparam logic [CYC_W-1:0] CYC_MAX   = 8'd255;
	localparam logic [DCNT_W-1:0] DIV_STEPS = 4'd8;

	typedef struct packed {
		logic [COLOR_W-1:0] color_first;
		logic [COLOR_W-1:0] color_second;
		logic [COLOR_W-1:0] color_third;
		logic [TRAIL_W-1:0] trail_length;
		logic [GAP_W-1:0]   color_gap;
		logic [SPEED_W-1:0] speed_hundredths;
		logic [LED_W-1:0]   led_count;
		logic [CYC_W-1:0]   target_cycles;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_WRAP,
		ST_SEL,
		ST_DIV,
		ST_SCALE,
		ST_EMIT
	} state_t;

endpackage

### hw/rtl/mcct_div.sv
// Iterative restoring divider for the trail brightness, one quotient bit per cycle.
// Depends on mcct_pkg; the quotient is known to fit in eight bits.
module mcct_div import mcct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W:0]    rem_q;
	logic [CH_W-1:0]   lo_q;
	logic [QUOT_W-1:0] quot_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q[DEN_W-1:0], lo_q[CH_W-1]};
	assign fits  = trial >= {1'b0, req.den};
	assign diff  = trial - {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {2'b00, req.num[NUM_W-1:CH_W]};
			lo_q   <= req.num[CH_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff : trial;
			lo_q   <= {lo_q[CH_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### hw/rtl/mcct_seq.sv
// Frame sequencer: position advance, per-pixel head select, scaling and output beat.
// Depends on mcct_pkg; drives the shared divider through div_req_t / div_rsp_t.
module mcct_seq import mcct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  pixel_index,
	output logic [CH_W-1:0]   red,
	output logic [CH_W-1:0]   green,
	output logic [CH_W-1:0]   blue,
	output logic              last_pixel,
	output logic              running,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp
);

	state_t state_q, state_d;

	logic [POS_W-1:0]   pos_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CYC_W-1:0]   cyc_q;
	logic [POS_W-1:0]   draw_pos_q;
	logic [LED_W-1:0]   pix_q;
	logic               run_q;
	logic [COLOR_W-1:0] col_q;
	logic [COLOR_W-1:0] rgb_q;

	logic [LED_W-1:0]   n0;
	logic [LED_W-1:0]   n_eff;
	logic [SP_W-1:0]    sp;
	logic [SP_W:0]      sp2;
	logic [POS_W-1:0]   total;
	logic [SPEED_W-1:0] speed_eff;
	logic               last_w;
	logic [CYC_W-1:0]   cyc_next;

	logic [COLOR_W-1:0] colors [3];
	logic [SP_W:0]      offs [3];
	logic signed [DIST_W-1:0] delta;
	logic               hit_full;
	logic               hit_trail;
	logic [COLOR_W-1:0] hit_col;
	logic [TRAIL_W-1:0] hit_m;
	logic [CH_W-1:0]    scaled [3];
	logic [2*CH_W-1:0]  prod [3];
	logic [CH_W-1:0]    chan [3];

	assign n0        = (cfg.led_count == '0) ? 7'd1 : cfg.led_count;
	assign n_eff     = (32'(n0) > MAX_LEDS) ? LED_W'(MAX_LEDS) : n0;
	assign sp        = SP_W'(cfg.trail_length) + SP_W'(cfg.color_gap);
	assign sp2       = {sp, 1'b0};
	assign total     = POS_W'(n_eff) + POS_W'(sp2) + POS_W'(cfg.trail_length);
	assign speed_eff = (cfg.speed_hundredths == '0) ? 10'd1 : cfg.speed_hundredths;
	assign last_w    = (pix_q == n_eff - 1'b1);
	assign cyc_next  = (pos_q >= total && cyc_q != CYC_MAX) ? cyc_q + 1'b1 : cyc_q;

	assign colors[0] = cfg.color_first;
	assign colors[1] = cfg.color_second;
	assign colors[2] = cfg.color_third;
	assign offs[0]   = '0;
	assign offs[1]   = {1'b0, sp};
	assign offs[2]   = sp2;

	always_comb begin
		hit_full  = 1'b0;
		hit_trail = 1'b0;
		hit_col   = '0;
		hit_m     = '0;
		delta     = '0;
		for (int k = 0; k < 3; k++) begin
			delta = $signed({2'b00, draw_pos_q}) - $signed({4'b0000, pix_q})
				- $signed({3'b000, offs[k]});
			if (delta == '0) begin
				hit_full  = 1'b1;
				hit_trail = 1'b0;
				hit_col   = colors[k];
			end else if (delta >= 11'sd1 && delta <= $signed({6'b0, cfg.trail_length})) begin
				hit_full  = 1'b0;
				hit_trail = 1'b1;
				hit_col   = colors[k];
				hit_m     = cfg.trail_length - delta[TRAIL_W-1:0] + 1'b1;
			end
		end
	end

	assign chan[0] = col_q[23:16];
	assign chan[1] = col_q[15:8];
	assign chan[2] = col_q[7:0];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c]   = chan[c] * div_rsp.quot;
			scaled[c] = prod[c][2*CH_W-1:CH_W]
				+ CH_W'(chan[c] != '0 && div_rsp.quot != '0);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ADV;
			ST_ADV:   if (acc_q < STEP_UNIT) state_d = ST_WRAP;
			ST_WRAP:  state_d = ST_SEL;
			ST_SEL:   state_d = hit_trail ? ST_DIV : ST_EMIT;
			ST_DIV:   if (div_rsp.done) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT:  if (out_ready) state_d = last_w ? ST_IDLE : ST_SEL;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_EMIT);
		div_req.start = (state_q == ST_SEL) && hit_trail;
		div_req.num   = {hit_m, 8'd0} - NUM_W'(hit_m);
		div_req.den   = DEN_W'(cfg.trail_length) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			acc_q   <= '0;
			cyc_q   <= '0;
			run_q   <= 1'b0;
			pix_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							pos_q <= '0;
							cyc_q <= '0;
							acc_q <= ACC_W'(speed_eff);
						end else begin
							acc_q <= acc_q + ACC_W'(speed_eff);
						end
					end
				end
				ST_ADV: begin
					if (acc_q >= STEP_UNIT) begin
						acc_q <= acc_q - STEP_UNIT;
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_WRAP: begin
					if (pos_q >= total) begin
						pos_q <= '0;
						acc_q <= '0;
					end
					cyc_q <= cyc_next;
					run_q <= cyc_next < cfg.target_cycles;
					pix_q <= '0;
				end
				ST_EMIT: begin
					if (out_ready && !last_w) pix_q <= pix_q + 1'b1;
				end
				ST_SEL, ST_DIV, ST_SCALE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) draw_pos_q <= restart ? '0 : pos_q;
		if (state_q == ST_SEL) begin
			col_q <= hit_col;
			rgb_q <= (hit_full) ? hit_col : '0;
		end
		if (state_q == ST_SCALE) rgb_q <= {scaled[0], scaled[1], scaled[2]};
	end

	assign pixel_index = pix_q[IDX_W-1:0];
	assign red         = rgb_q[23:16];
	assign green       = rgb_q[15:8];
	assign blue        = rgb_q[7:0];
	assign last_pixel  = last_w;
	assign running     = run_q;

endmodule

### hw/rtl/multi_color_chase_with_trails_unit.sv
// Multi-color chase with fading trails: each input beat is a frame tick and yields one
// output beat per LED, index 0 to led_count-1 (held to 1..64), last_pixel on the last.
// Configuration: cfg_we / cfg_index / cfg_wdata write one register per cycle; write
// only while the block is idle (in_ready high and no pixel pending).
// Three heads at position, position-S and position-2S (S = trail + gap) are drawn,
// later colors winning; trail pixels are scaled through one shared 8-step divider.
// After the input beat the position advances by one per whole step held in the
// accumulator (up to 11 steps), then the wrap state follows. Each pixel then passes
// select and emit when black or a head, and select, divider, scale and emit on a
// trail pixel.
// in_ready is high only between frames; a stalled receiver holds the current pixel
// and the sequencer until out_ready returns.
// Reset restores every configuration register to its default and clears position, step
// accumulator and completed-pass count; running reads 0 until the first frame.
// Depends on mcct_pkg, mcct_seq and mcct_div.
module multi_color_chase_with_trails_unit import mcct_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      pixel_index,
	output logic [CH_W-1:0]       red,
	output logic [CH_W-1:0]       green,
	output logic [CH_W-1:0]       blue,
	output logic                  last_pixel,
	output logic                  running
);

	cfg_t     cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_first      <= RST_COLOR_FIRST;
			cfg_q.color_second     <= RST_COLOR_SECOND;
			cfg_q.color_third      <= RST_COLOR_THIRD;
			cfg_q.trail_length     <= RST_TRAIL;
			cfg_q.color_gap        <= RST_GAP;
			cfg_q.speed_hundredths <= RST_SPEED;
			cfg_q.led_count        <= RST_LED_COUNT;
			cfg_q.target_cycles    <= RST_TARGET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLOR_FIRST:  cfg_q.color_first      <= cfg_wdata;
				CFG_COLOR_SECOND: cfg_q.color_second     <= cfg_wdata;
				CFG_COLOR_THIRD:  cfg_q.color_third      <= cfg_wdata;
				CFG_TRAIL_LENGTH: cfg_q.trail_length     <= cfg_wdata[TRAIL_W-1:0];
				CFG_COLOR_GAP:    cfg_q.color_gap        <= cfg_wdata[GAP_W-1:0];
				CFG_SPEED:        cfg_q.speed_hundredths <= cfg_wdata[SPEED_W-1:0];
				CFG_LED_COUNT:    cfg_q.led_count        <= cfg_wdata[LED_W-1:0];
				CFG_TARGET:       cfg_q.target_cycles    <= cfg_wdata[CYC_W-1:0];
			endcase
		end
	end

	mcct_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel),
		.running     (running),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	mcct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### hw/rtl/mcct_checker.sv
// Port-level checker for the multi-color chase unit, bound to the top level.
// Depends on mcct_pkg for field widths.
module mcct_checker import mcct_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  restart,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [IDX_W-1:0]      pixel_index,
	input logic [CH_W-1:0]       red,
	input logic [CH_W-1:0]       green,
	input logic [CH_W-1:0]       blue,
	input logic                  last_pixel,
	input logic                  running
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_pixel) && $stable(running))
		else $error("stalled output beat changed");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a pixel is pending");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_pixel |=> in_ready && !out_valid)
		else $error("not idle after last pixel");

	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> !in_ready)
		else $error("idle before frame end");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("frame tick not held in advance");

endmodule

bind multi_color_chase_with_trails_unit mcct_checker u_mcct_checker (.*);
